/* rtl/min_max_normalize_to_byte_macros.svh */
// Assertion macros shared by the min/max normalizer RTL.
// Every macro expects clk and rst_n in scope.
`ifndef MIN_MAX_NORMALIZE_TO_BYTE_MACROS_SVH
`define MIN_MAX_NORMALIZE_TO_BYTE_MACROS_SVH

// Property must hold at every edge outside reset.
`define MMNB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define MMNB_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/mmnb_pkg.sv */
// Package for the min/max normalizer: word types, controller/datapath
// command and status structs, shared constants. No dependencies.
`default_nettype none

package mmnb_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int LEVEL_BITS  = 8;
  localparam int DIV_STEPS   = LEVEL_BITS;
  localparam int PROD_BITS   = SAMPLE_BITS + LEVEL_BITS;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic    operation;
    sample_t sample;
    logic    first_sample;
  } in_word_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic                  flat;
  } out_word_t;

  typedef struct packed {
    logic accept;  // input word taken this cycle
    logic load;    // classify sample, set up divider
    logic step;    // one restoring-division step
    logic emit;    // move result into output register
  } dp_cmd_t;

  typedef struct packed {
    logic bypass;  // result known without division
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/min_max_normalize_to_byte.sv */
// Min/max normalizer to 8-bit levels. Measure words (operation 0) update a
// running signed minimum and maximum in the cycle they are taken, one word per
// cycle while no convert word is in progress; first_sample restarts both at
// that sample. Convert words (operation 1) return one word: level =
// floor((sample-min)*255/(max-min)), 0 below the minimum, 255 above the
// maximum, and level 0 with flat set when max <= min. A convert word stalls
// the input through take, setup, 8 steps of a one-bit restoring divider and
// hand-off to the output register; when no division is needed the steps are
// skipped. The output register lets the next word be taken while a result
// waits on out_stall. Depends on mmnb_pkg, mmnb_ctrl and mmnb_dp.
`default_nettype none

module min_max_normalize_to_byte (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  mmnb_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  wire                  out_stall,
  output mmnb_pkg::out_word_t  out_word
);
  import mmnb_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mmnb_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_word.operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .stat         (stat)
  );

  mmnb_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .stat     (stat),
    .out_word (out_word)
  );

endmodule

`default_nettype wire

/* rtl/mmnb_ctrl.sv */
// Controller FSM for the min/max normalizer: input handshake, divider
// step count, output valid. Uses mmnb_pkg and the assertion macros.
`default_nettype none

module mmnb_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_operation,
  output logic                in_stall,
  output logic                out_valid,
  input  wire                 out_stall,
  output mmnb_pkg::dp_cmd_t   cmd,
  input  mmnb_pkg::dp_stat_t  stat
);
  import mmnb_pkg::*;

  `include "min_max_normalize_to_byte_macros.svh"

  localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             emit_ok;

  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    accept     = in_valid && !in_stall;
    emit_ok    = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
    cmd.accept = accept;
    cmd.load   = (state_r == ST_LOAD);
    cmd.step   = (state_r == ST_DIV) && !stat.bypass;
    cmd.emit   = emit_ok;
    out_valid  = out_valid_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_operation == OP_CONVERT)) state_nxt = ST_LOAD;
      end
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (stat.bypass || (cnt_r == CNT_LAST)) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_ok) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = '0;
    if (cmd.step && (cnt_r != CNT_LAST)) cnt_nxt = cnt_r + 1'b1;
  end

  always_comb begin
    if (emit_ok) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `MMNB_ASSERT(a_emit_to_idle, cmd.emit |=> (state_r == ST_IDLE), "emit did not return to idle")
  `MMNB_ASSERT(a_valid_from_emit, $rose(out_valid_r) |-> $past(state_r == ST_EMIT),
               "output valid rose without an emit")
  `MMNB_NEVER(a_cnt_outside_div, (state_r != ST_DIV) && (cnt_r != '0),
              "step count nonzero outside division")

endmodule

`default_nettype wire

/* rtl/mmnb_dp.sv */
// Datapath for the min/max normalizer: running extremes, range/offset
// setup, 8-step restoring divider, output register. Uses mmnb_pkg.
`default_nettype none

module mmnb_dp (
  input  wire                  clk,
  input  wire                  rst_n,
  input  mmnb_pkg::in_word_t   in_word,
  input  mmnb_pkg::dp_cmd_t    cmd,
  output mmnb_pkg::dp_stat_t   stat,
  output mmnb_pkg::out_word_t  out_word
);
  import mmnb_pkg::*;

  `include "min_max_normalize_to_byte_macros.svh"

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  sample_t               min_r, max_r, sample_r;
  logic [SAMPLE_BITS-1:0] rem_r, rng_r;
  logic [LEVEL_BITS-1:0]  q_r;
  logic                   bypass_r, flat_r;
  out_word_t              out_r;

  logic signed [SAMPLE_BITS:0] s_x, mn_x, mx_x, range_x, off_x;
  logic [PROD_BITS-1:0]        prod;
  logic                        is_flat, below, above;
  logic [SAMPLE_BITS:0]        trial;
  logic                        fits;

  // setup: offset*255 as (offset<<8) - offset; range fits SAMPLE_BITS unsigned
  always_comb begin
    s_x     = {sample_r[SAMPLE_BITS-1], sample_r};
    mn_x    = {min_r[SAMPLE_BITS-1], min_r};
    mx_x    = {max_r[SAMPLE_BITS-1], max_r};
    range_x = mx_x - mn_x;
    off_x   = s_x - mn_x;
    is_flat = (max_r <= min_r);
    below   = (sample_r <= min_r);
    above   = (sample_r >= max_r);
    prod    = {off_x[SAMPLE_BITS-1:0], {LEVEL_BITS{1'b0}}}
            - {{LEVEL_BITS{1'b0}}, off_x[SAMPLE_BITS-1:0]};
  end

  // restoring step: bring in next dividend bit from top of q_r
  always_comb begin
    trial = {rem_r, q_r[LEVEL_BITS-1]};
    fits  = (trial >= {1'b0, rng_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= SAMPLE_MAX;
      max_r <= SAMPLE_MIN;
    end else if (cmd.accept && (in_word.operation == OP_MEASURE)) begin
      if (in_word.first_sample) begin
        min_r <= in_word.sample;
        max_r <= in_word.sample;
      end else begin
        if (in_word.sample < min_r) min_r <= in_word.sample;
        if (in_word.sample > max_r) max_r <= in_word.sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) sample_r <= in_word.sample;
    if (cmd.load) begin
      bypass_r <= is_flat || below || above;
      flat_r   <= is_flat;
      rng_r    <= range_x[SAMPLE_BITS-1:0];
      rem_r    <= prod[PROD_BITS-1:LEVEL_BITS];
      if (is_flat || below) begin
        q_r <= '0;
      end else if (above) begin
        q_r <= LEVEL_MAX;
      end else begin
        q_r <= prod[LEVEL_BITS-1:0];
      end
    end else if (cmd.step) begin
      rem_r <= fits ? (trial[SAMPLE_BITS-1:0] - rng_r) : trial[SAMPLE_BITS-1:0];
      q_r   <= {q_r[LEVEL_BITS-2:0], fits};
    end
    if (cmd.emit) begin
      out_r.level <= q_r;
      out_r.flat  <= flat_r;
    end
  end

  assign stat.bypass = bypass_r;
  assign out_word    = out_r;

  `MMNB_ASSERT(a_rem_below_range, cmd.step |-> (rem_r < rng_r),
               "divider remainder not below range")
  `MMNB_ASSERT(a_extremes_ordered,
               ($past(rst_n) && $past(cmd.accept && (in_word.operation == OP_MEASURE)))
               |-> (min_r <= max_r), "minimum above maximum after measure")

endmodule

`default_nettype wire
